// File: sv/pcmfc_pkg.sv
// pcmfc_pkg: format codes, config index codes and the shared format type for the pcm sample format converter
// no dependencies
`default_nettype none
package pcmfc_pkg;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_U8  = 3'd0;
  localparam fmt_t FMT_S16 = 3'd1;
  localparam fmt_t FMT_S32 = 3'd2;
  localparam fmt_t FMT_F32 = 3'd3;
  localparam fmt_t FMT_F64 = 3'd4;

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  localparam fmt_t FMT_RESET = FMT_S16;

endpackage
`default_nettype wire

// File: sv/pcm_sample_format_converter.sv
// pcm_sample_format_converter: five-format pcm sample conversion, four register stages
// uses pcmfc_pkg for format codes
// throughput: one sample per cycle while out_ready does not stall the output
// stages: input capture, sign/leading-zero count, normalize, round/saturate and select
// a stalled output holds the last stage; earlier stages hold only while full and keep filling bubbles
// rst (synchronous) empties the pipeline and sets both formats to signed 16-bit
`default_nettype none
module pcm_sample_format_converter (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [63:0] sample_bits,
  input  wire         silent_sample,
  input  wire         end_of_block,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] converted_bits,
  output logic        block_done,
  input  wire         cfg_write,
  input  wire         cfg_index,
  input  wire  [2:0]  cfg_data
);

  pcmfc_pkg::fmt_t src_fmt, dst_fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_fmt <= pcmfc_pkg::FMT_RESET;
      dst_fmt <= pcmfc_pkg::FMT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == pcmfc_pkg::CFG_SOURCE) src_fmt <= cfg_data;
      else dst_fmt <= cfg_data;
    end
  end

  // round to nearest even of sig >> sh, sh is at least 21
  function automatic logic [32:0] rne_shr(input logic [52:0] sig, input logic [5:0] sh);
    logic [63:0] s64, q, rem, half;
    s64  = {11'd0, sig};
    q    = s64 >> sh;
    rem  = s64 & ~(64'hffff_ffff_ffff_ffff << sh);
    half = 64'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q[32:0];
  endfunction

  // stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  // stage 1: capture
  logic [63:0] x1;
  logic        sil1, eob1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en1) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en1) begin
      x1   <= sample_bits;
      sil1 <= silent_sample;
      eob1 <= end_of_block;
    end
  end

  // stage A: silence, integer word, magnitude and leading zeros
  logic [63:0] xa;
  logic [31:0] wa, maga;
  logic [5:0]  lza;
  logic [4:0]  lzsa;

  always_comb begin
    xa = sil1 ? ((src_fmt == pcmfc_pkg::FMT_U8) ? 64'h80 : 64'h0) : x1;
    case (src_fmt)
      pcmfc_pkg::FMT_U8:  wa = {xa[7:0] ^ 8'h80, 24'h0};
      pcmfc_pkg::FMT_S16: wa = {xa[15:0], 16'h0};
      default:            wa = xa[31:0];
    endcase
    maga = wa[31] ? (~wa + 32'd1) : wa;
    lza = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (maga[i]) lza = 6'(31 - i);
    end
    lzsa = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (xa[i]) lzsa = 5'(22 - i);
    end
  end

  logic [63:0] x2;
  logic [31:0] w2, mag2;
  logic [5:0]  lz2;
  logic [4:0]  lzs2;
  logic        eob2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en2) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en2) begin
      x2   <= xa;
      w2   <= wa;
      mag2 <= maga;
      lz2  <= lza;
      lzs2 <= lzsa;
      eob2 <= eob1;
    end
  end

  // stage B: normalize integer, integer to float, single to double
  logic [31:0] norm;
  logic        rnd_b;
  logic [30:0] i2s_mag;
  logic [31:0] i2s_b;
  logic [63:0] i2d_b, s2d_b, db_b;
  logic [7:0]  se;
  logic [22:0] sm;
  logic [4:0]  kk;
  logic [23:0] m24;

  always_comb begin
    norm    = mag2 << lz2;
    i2d_b   = (mag2 == 32'd0) ? 64'd0 :
              {w2[31], 11'(11'd1023 - 11'(lz2)), norm[30:0], 21'd0};
    rnd_b   = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
    i2s_mag = {8'(8'd127 - 8'(lz2)), norm[30:8]} + 31'(rnd_b);
    i2s_b   = (mag2 == 32'd0) ? 32'd0 : {w2[31], i2s_mag};

    se  = x2[30:23];
    sm  = x2[22:0];
    kk  = lzs2 + 5'd1;
    m24 = {1'b0, sm} << kk;
    if (se == 8'hff) begin
      if (sm == 23'd0) s2d_b = {x2[31], 11'h7ff, 52'd0};
      else s2d_b = {x2[31], 11'h7ff, 1'b1, sm[21:0], 29'd0};
    end else if (se == 8'd0) begin
      if (sm == 23'd0) s2d_b = {x2[31], 63'd0};
      else s2d_b = {x2[31], 11'(11'd897 - 11'(kk)), m24[22:0], 29'd0};
    end else begin
      s2d_b = {x2[31], 11'(se) + 11'd896, sm, 29'd0};
    end
    db_b = (src_fmt == pcmfc_pkg::FMT_F32) ? s2d_b : x2;
  end

  logic [31:0] x3, w3, i2s3;
  logic [63:0] db3, i2d3;
  logic        eob3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en3) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en3) begin
      x3   <= x2[31:0];
      w3   <= w2;
      db3  <= db_b;
      i2s3 <= i2s_b;
      i2d3 <= i2d_b;
      eob3 <= eob2;
    end
  end

  // stage C: double to single, float to integer, final select
  logic        ds;
  logic [10:0] de;
  logic [51:0] dm;
  logic [52:0] sig;
  logic [11:0] tsh;
  logic [5:0]  sh_d, sh_i;
  logic [32:0] qd, qi;
  logic [33:0] nrm;
  logic [31:0] d2s;
  logic [10:0] kq, lo, hi;
  logic signed [33:0] r, t;
  logic [31:0] f2i;
  logic [63:0] res;

  always_comb begin
    ds  = db3[63];
    de  = db3[62:52];
    dm  = db3[51:0];
    sig = {1'b1, dm};

    tsh  = 12'd926 - {1'b0, de};
    if (de >= 11'd897) sh_d = 6'd29;
    else if (tsh > 12'd63) sh_d = 6'd63;
    else sh_d = tsh[5:0];
    qd  = rne_shr(sig, sh_d);
    nrm = {de - 11'd897, 23'd0} + {1'b0, qd};
    if (de == 11'h7ff) begin
      if (dm == 52'd0) d2s = {ds, 31'h7f800000};
      else d2s = {ds, 31'h7fc00000 | {8'd0, dm[51:29]}};
    end else if (de == 11'd0) begin
      d2s = {ds, 31'd0};
    end else if (de > 11'd1150) begin
      d2s = {ds, 31'h7f800000};
    end else if (de >= 11'd897) begin
      d2s = {ds, nrm[30:0]};
    end else begin
      d2s = {ds, qd[30:0]};
    end

    case (dst_fmt)
      pcmfc_pkg::FMT_S16: kq = 11'd15;
      pcmfc_pkg::FMT_S32: kq = 11'd31;
      default:            kq = 11'd7;
    endcase
    lo   = 11'd1021 - kq;
    hi   = 11'd1054 - kq;
    sh_i = 6'(11'd1075 - kq - de);
    qi   = rne_shr(sig, sh_i);
    if (de == 11'h7ff) begin
      if (dm != 52'd0) r = 34'sd0;
      else r = ds ? -34'sh1_0000_0000 : 34'sh1_0000_0000;
    end else if (de == 11'd0 || de < lo) begin
      r = 34'sd0;
    end else if (de >= hi) begin
      r = ds ? -34'sh1_0000_0000 : 34'sh1_0000_0000;
    end else begin
      r = ds ? -$signed({1'b0, qi}) : $signed({1'b0, qi});
    end

    case (dst_fmt)
      pcmfc_pkg::FMT_U8: begin
        t = r + 34'sd128;
        if (t < 34'sd0) f2i = 32'd0;
        else if (t > 34'sd255) f2i = 32'd255;
        else f2i = {24'd0, t[7:0]};
      end
      pcmfc_pkg::FMT_S16: begin
        t = r;
        if (t < -34'sd32768) f2i = 32'h8000;
        else if (t > 34'sd32767) f2i = 32'h7fff;
        else f2i = {16'd0, t[15:0]};
      end
      default: begin
        t = r;
        if (t < -34'sh8000_0000) f2i = 32'h8000_0000;
        else if (t > 34'sh7fff_ffff) f2i = 32'h7fff_ffff;
        else f2i = t[31:0];
      end
    endcase

    if (src_fmt > pcmfc_pkg::FMT_F64 || dst_fmt > pcmfc_pkg::FMT_F64) begin
      res = 64'd0;
    end else if (src_fmt <= pcmfc_pkg::FMT_S32) begin
      case (dst_fmt)
        pcmfc_pkg::FMT_U8:  res = {56'd0, w3[31:24] ^ 8'h80};
        pcmfc_pkg::FMT_S16: res = {48'd0, w3[31:16]};
        pcmfc_pkg::FMT_S32: res = {32'd0, w3};
        pcmfc_pkg::FMT_F32: res = {32'd0, i2s3};
        default:            res = i2d3;
      endcase
    end else begin
      case (dst_fmt)
        pcmfc_pkg::FMT_F32: res = (src_fmt == pcmfc_pkg::FMT_F32) ? {32'd0, x3} : {32'd0, d2s};
        pcmfc_pkg::FMT_F64: res = db3;
        default:            res = {32'd0, f2i};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en4) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en4) begin
      converted_bits <= res;
      block_done     <= eob3;
    end
  end

endmodule
`default_nettype wire
